// ===== src/chol_pkg.sv =====
`timescale 1ns / 1ps
package chol_pkg;

    localparam int MAX_SIZE   = 8;
    localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
    localparam int AW         = $clog2(DEPTH);
    localparam int IW         = $clog2(MAX_SIZE);
    localparam int SW         = $clog2(MAX_SIZE + 1);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int ACC_W      = 52;
    localparam logic [3:0] SIZE_RESET = 4'd4;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_ROW,
        ST_DIAG_A,
        ST_DIAG_RD,
        ST_DIAG_MUL,
        ST_DIAG_ACC,
        ST_DIAG_REM,
        ST_SQRT,
        ST_SQRT_WR,
        ST_OFF_A,
        ST_OFF_RD,
        ST_OFF_MUL,
        ST_OFF_PROD,
        ST_OFF_ACC,
        ST_OFF_REM,
        ST_DIV,
        ST_DIV_WR,
        ST_EMIT_RD,
        ST_EMIT,
        ST_ERROR
    } state_t;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] rem;
        logic [31:0] divisor;
    } math_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] result;
    } math_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = ACC_W'(64'sh7fffffff);
            lo = -ACC_W'(64'sh80000000);
            if (v > hi)
                sat32 = 32'sh7fffffff;
            else if (v < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== src/chol_ram.sv =====
`timescale 1ns / 1ps
module chol_ram #(
    parameter int AWIDTH = 6,
    parameter int DWIDTH = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AWIDTH-1:0] waddr,
    input  logic [DWIDTH-1:0] wdata,
    input  logic [AWIDTH-1:0] raddr,
    output logic [DWIDTH-1:0] rdata
);

    logic [DWIDTH-1:0] mem [2**AWIDTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== src/chol_math.sv =====
`timescale 1ns / 1ps
module chol_math
    import chol_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  math_req_t req,
    output math_rsp_t rsp
);

    // sqrt: floor(sqrt(rem << 16)), 24 result bits, one per cycle
    // div : (rem << 16) / divisor, 48 quotient bits, one per cycle, then saturate
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        is_div_reg, is_div_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] num_reg, num_next;
    logic [49:0] part_reg, part_next;
    logic [47:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] res_reg, res_next;

    logic [49:0] trial;
    logic [49:0] shifted;
    logic [31:0] rem_abs;
    logic [31:0] den_abs;
    logic [48:0] qs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        num_reg    <= num_next;
        part_reg   <= part_next;
        quo_reg    <= quo_next;
        den_reg    <= den_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        part_next   = part_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        res_next    = res_reg;
        rem_abs     = req.rem[31] ? 32'(-req.rem) : req.rem;
        den_abs     = req.divisor[31] ? 32'(-req.divisor) : req.divisor;
        trial       = '0;
        shifted     = '0;
        qs          = '0;

        if (req.start)
        begin
            busy_next   = 1'b1;
            is_div_next = req.is_div;
            neg_next    = req.rem[31] ^ req.divisor[31];
            num_next    = {rem_abs, 16'd0};
            part_next   = '0;
            quo_next    = '0;
            den_next    = den_abs;
            cnt_next    = req.is_div ? 6'd48 : 6'd24;
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                shifted = {part_reg[48:0], num_reg[47]};
                num_next = {num_reg[46:0], 1'b0};
                if (shifted >= {18'd0, den_reg})
                begin
                    part_next = shifted - {18'd0, den_reg};
                    quo_next  = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    part_next = shifted;
                    quo_next  = {quo_reg[46:0], 1'b0};
                end
            end
            else
            begin
                shifted  = {part_reg[47:0], num_reg[47:46]};
                num_next = {num_reg[45:0], 2'b00};
                trial    = {24'd0, quo_reg[23:0], 2'b01};
                if (shifted >= trial)
                begin
                    part_next = shifted - trial;
                    quo_next  = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    part_next = shifted;
                    quo_next  = {quo_reg[46:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (is_div_reg)
                begin
                    qs = neg_reg ? 49'(-{1'b0, quo_next}) : {1'b0, quo_next};
                    if (!neg_reg && quo_next > 48'h7fffffff)
                        res_next = 32'h7fffffff;
                    else if (neg_reg && quo_next > 48'h80000000)
                        res_next = 32'h80000000;
                    else
                        res_next = qs[31:0];
                end
                else
                    res_next = quo_next[31:0];
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ===== src/chol_ctrl.sv =====
`timescale 1ns / 1ps
module chol_ctrl
    import chol_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] element_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] factor_value,
    output logic        not_positive_definite,
    output logic        last_result
);

    state_t      state_reg, state_next;
    logic [3:0]  size_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic [31:0] u_a_reg, u_b_reg;
    logic [31:0] diag_reg, diag_next;
    logic [31:0] rem_reg, rem_next;
    logic        ov_reg, ov_next;
    logic [31:0] fv_reg, fv_next;
    logic        fe_reg, fe_next, fl_reg, fl_next;
    logic [AW-1:0] e_reg, e_next;
    logic        sec_reg, sec_next;

    logic [SW-1:0] n;
    logic [CW-1:0] total;
    logic        a_we, f_we;
    logic [AW-1:0] a_waddr, a_raddr, f_waddr, f_raddr;
    logic [31:0] a_wdata, f_wdata, a_rdata, f_rdata;
    logic        in_fire;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] diff;
    logic signed [63:0] pabs;
    math_req_t   mreq;
    math_rsp_t   mrsp;

    function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                           input logic [SW-1:0] sz);
        logic [AW+SW-1:0] t;
        begin
            t = (AW+SW)'(r) * (AW+SW)'(sz) + (AW+SW)'(c);
            addr = t[AW-1:0];
        end
    endfunction

    always_comb
    begin
        if (size_reg == 4'd0)
            n = SW'(1);
        else if (size_reg > 4'(MAX_SIZE))
            n = SW'(MAX_SIZE);
        else
            n = size_reg[SW-1:0];
        total = CW'(n) * CW'(n);
    end

    chol_ram #(.AWIDTH(AW), .DWIDTH(32)) u_a_ram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata));

    chol_ram #(.AWIDTH(AW), .DWIDTH(32)) u_f_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));

    chol_math u_math (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= SIZE_RESET;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                size_reg  <= cfg_wdata;
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        diag_reg <= diag_next;
        rem_reg  <= rem_next;
        fv_reg   <= fv_next;
        fe_reg   <= fe_next;
        fl_reg   <= fl_next;
        e_reg    <= e_next;
        sec_reg  <= sec_next;
        u_a_reg  <= f_rdata;
        prod_reg <= $signed(u_a_reg) * $signed(u_b_reg);
        if (sec_reg)
            u_b_reg <= f_rdata;
    end

    assign in_fire = in_valid && in_ready;
    assign in_ready = (state_reg == ST_LOAD);
    assign out_valid = ov_reg;
    assign factor_value = fv_reg;
    assign not_positive_definite = fe_reg;
    assign last_result = fl_reg;

    always_comb
    begin
        pabs = prod_reg[63] ? -prod_reg : prod_reg;
        pabs = (pabs + 64'sd32768) >>> 16;
        rnd  = prod_reg[63] ? -ACC_W'(pabs) : ACC_W'(pabs);
        diff = ACC_W'($signed(a_rdata)) - acc_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg;
        acc_next = acc_reg;
        diag_next = diag_reg;
        rem_next = rem_reg;
        e_next = e_reg;
        sec_next = 1'b0;
        ov_next = ov_reg;
        fv_next = fv_reg; fe_next = fe_reg; fl_next = fl_reg;
        a_we = 1'b0; a_waddr = count_reg[AW-1:0]; a_wdata = element_value;
        a_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        mreq.start = 1'b0; mreq.is_div = 1'b0; mreq.rem = rem_reg; mreq.divisor = diag_reg;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    a_we = 1'b1;
                    if (count_reg >= total)
                        a_waddr = '0;
                    if ((count_reg >= total ? CW'(1) : count_reg + CW'(1)) == total)
                    begin
                        count_next = '0;
                        e_next = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                        count_next = (count_reg >= total) ? CW'(1) : count_reg + CW'(1);
                end
            end
            ST_CLEAR:
            begin
                f_we = 1'b1;
                f_waddr = e_reg;
                e_next = e_reg + AW'(1);
                if (CW'(e_reg) + CW'(1) == total)
                begin
                    i_next = '0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                acc_next = '0;
                k_next = '0;
                state_next = ST_DIAG_A;
            end
            ST_DIAG_A:
            begin
                a_raddr = addr(i_reg, i_reg, n);
                f_raddr = addr(k_reg, i_reg, n);
                state_next = (k_reg == i_reg) ? ST_DIAG_REM : ST_DIAG_RD;
                sec_next = 1'b1;
            end
            ST_DIAG_RD:  state_next = ST_DIAG_MUL;
            ST_DIAG_MUL: state_next = ST_DIAG_ACC;
            ST_DIAG_ACC:
            begin
                acc_next = acc_reg + rnd;
                k_next = k_reg + IW'(1);
                state_next = ST_DIAG_A;
            end
            ST_DIAG_REM:
            begin
                rem_next = sat32(diff);
                if (sat32(diff) <= 0)
                    state_next = ST_ERROR;
                else
                begin
                    mreq.start = 1'b1;
                    mreq.rem = sat32(diff);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
                if (mrsp.done)
                    state_next = ST_SQRT_WR;
            ST_SQRT_WR:
            begin
                diag_next = mrsp.result;
                f_we = 1'b1;
                f_waddr = addr(i_reg, i_reg, n);
                f_wdata = mrsp.result;
                j_next = i_reg + IW'(1);
                if (SW'(i_reg) + SW'(1) == n)
                begin
                    e_next = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    acc_next = '0;
                    k_next = '0;
                    state_next = ST_OFF_A;
                end
            end
            ST_OFF_A:
            begin
                a_raddr = addr(i_reg, j_reg, n);
                f_raddr = addr(k_reg, i_reg, n);
                sec_next = 1'b1;
                state_next = (k_reg == i_reg) ? ST_OFF_REM : ST_OFF_RD;
            end
            ST_OFF_RD:
            begin
                f_raddr = addr(k_reg, j_reg, n);
                state_next = ST_OFF_MUL;
            end
            ST_OFF_MUL:  state_next = ST_OFF_PROD;
            ST_OFF_PROD: state_next = ST_OFF_ACC;
            ST_OFF_ACC:
            begin
                acc_next = acc_reg + rnd;
                k_next = k_reg + IW'(1);
                state_next = ST_OFF_A;
            end
            ST_OFF_REM:
            begin
                rem_next = sat32(diff);
                mreq.start = 1'b1;
                mreq.is_div = 1'b1;
                mreq.rem = sat32(diff);
                state_next = ST_DIV;
            end
            ST_DIV:
                if (mrsp.done)
                    state_next = ST_DIV_WR;
            ST_DIV_WR:
            begin
                f_we = 1'b1;
                f_waddr = addr(i_reg, j_reg, n);
                f_wdata = mrsp.result;
                acc_next = '0;
                k_next = '0;
                if (SW'(j_reg) + SW'(1) == n)
                begin
                    i_next = i_reg + IW'(1);
                    state_next = ST_ROW;
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                    state_next = ST_OFF_A;
                end
            end
            ST_EMIT_RD:
            begin
                f_raddr = e_reg;
                if (!ov_reg || out_ready)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                ov_next = 1'b1;
                fv_next = f_rdata;
                fe_next = 1'b0;
                fl_next = (CW'(e_reg) + CW'(1) == total);
                e_next = e_reg + AW'(1);
                state_next = (CW'(e_reg) + CW'(1) == total) ? ST_LOAD : ST_EMIT_RD;
            end
            ST_ERROR:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    fv_next = '0;
                    fe_next = 1'b1;
                    fl_next = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

endmodule

// ===== src/cholesky_decomposition_top.sv =====
`timescale 1ns / 1ps
// Loading: one word per cycle, N*N words per matrix, no result until the last.
// Factoring: multiply-adds pass the address, read, multiply (off the diagonal also product) and
// accumulate states; square roots and divisions share the iterative unit; results then go out.
// Throughput is set by the one-read-port factor memory and the serial math unit.
// Reset (rst_n, asynchronous, active low) sets the size to 4 and clears the count.
module cholesky_decomposition_top
    import chol_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] element_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] factor_value,
    output logic        not_positive_definite,
    output logic        last_result
);

    chol_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .element_value(element_value),
        .out_valid(out_valid), .out_ready(out_ready), .factor_value(factor_value),
        .not_positive_definite(not_positive_definite), .last_result(last_result));

endmodule

// ===== src/chol_checker.sv =====
`timescale 1ns / 1ps
module chol_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] factor_value,
    input logic        not_positive_definite,
    input logic        last_result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(factor_value))
        else $error("result word dropped");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_positive_definite |-> last_result && factor_value == 32'd0)
        else $error("error word malformed");

    a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> !in_ready)
        else $error("input taken mid-emit");

    a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !not_positive_definite |-> !factor_value[31] || !last_result)
        else $error("negative last diagonal");

endmodule

bind cholesky_decomposition_top chol_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .factor_value(factor_value),
    .not_positive_definite(not_positive_definite), .last_result(last_result));
